// ===== rtl/core/lfu_cache_lookup_update_macros.svh =====
// Assertion macros shared by the LFU cache RTL.
`ifndef LFU_CACHE_LOOKUP_UPDATE_MACROS_SVH
`define LFU_CACHE_LOOKUP_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
`define LFU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lfu assertion failed");
`define LFU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lfu implication failed");
`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lfu sequence failed");
`else
`define LFU_ASSERT(lbl, clk, rstn, prop)
`define LFU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/lfu_pkg.sv =====
// Package: shared types and constants of the LFU cache.
package lfu_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CapW   = 5;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CapW-1:0]   CapReset = CapW'(16);

  typedef enum logic [0:0] {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } lfu_act_e;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } lfu_reg_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EVICT = 4'b1000
  } lfu_state_e;

  typedef struct packed {
    logic apply;
    logic age_all;
    logic install;
    logic wr_value;
  } lfu_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] count;
  } lfu_cand_t;

endpackage

// ===== rtl/core/lfu_ifs.sv =====
// Interfaces: request and response channels of the LFU cache.
interface lfu_req_if;
  import lfu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic signed [KeyW-1:0] key;
  logic signed [ValW-1:0] write_value;
  modport source (output valid, action, key, write_value, input ready);
  modport sink (input valid, action, key, write_value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic signed [ValW-1:0] read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface

// ===== rtl/core/lfu_cell.sv =====
// Cache cell: one entry plus one stage of the victim search chain.
module lfu_cell import lfu_pkg::*; #(
  parameter int unsigned RW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lfu_ctl_t        ctl_i,
  input  logic            sel_i,
  input  logic [RW-1:0]   ref_rank_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_i,
  input  lfu_cand_t       cand_i,
  input  logic [RW-1:0]   cand_rank_i,
  input  logic [RW-1:0]   cand_idx_i,
  output lfu_cand_t       cand_o,
  output logic [RW-1:0]   cand_rank_o,
  output logic [RW-1:0]   cand_idx_o,
  output logic            valid_o,
  output logic            match_o,
  output logic [ValW-1:0] value_o,
  output logic [RW-1:0]   rank_o
);

  logic              valid_q, valid_d;
  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   value_q;
  logic [CountW-1:0] count_q;
  logic [RW-1:0]     rank_q;
  lfu_cand_t         cand_q, cand_d;
  logic [RW-1:0]     cand_rank_q, cand_rank_d;
  logic [RW-1:0]     cand_idx_q, cand_idx_d;
  logic              take_in;

  assign valid_d = valid_q | (ctl_i.apply & sel_i & ctl_i.install);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.apply) begin
      if (sel_i) begin
        rank_q <= '0;
        if (ctl_i.install) begin
          key_q   <= key_i;
          value_q <= value_i;
          count_q <= CountW'(1);
        end else begin
          if (count_q != CountMax) count_q <= count_q + CountW'(1);
          if (ctl_i.wr_value) value_q <= value_i;
        end
      end else if (valid_q && (ctl_i.age_all || rank_q < ref_rank_i)) begin
        rank_q <= rank_q + RW'(1);
      end
    end
  end

  // smaller count wins, older entry on a tie
  assign take_in = cand_i.valid && (!valid_q || cand_i.count < count_q ||
                   (cand_i.count == count_q && cand_rank_i > rank_q));

  always_comb begin
    if (take_in) begin
      cand_d      = cand_i;
      cand_rank_d = cand_rank_i;
      cand_idx_d  = cand_idx_i;
    end else begin
      cand_d      = '{valid: valid_q, count: count_q};
      cand_rank_d = rank_q;
      cand_idx_d  = RW'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= '0;
      cand_rank_q <= '0;
      cand_idx_q  <= '0;
    end else begin
      cand_q      <= cand_d;
      cand_rank_q <= cand_rank_d;
      cand_idx_q  <= cand_idx_d;
    end
  end

  assign cand_o      = cand_q;
  assign cand_rank_o = cand_rank_q;
  assign cand_idx_o  = cand_idx_q;
  assign valid_o     = valid_q;
  assign match_o     = valid_q && (key_q == key_i);
  assign value_o     = value_q;
  assign rank_o      = rank_q;

endmodule

// ===== rtl/core/lfu_cache_lookup_update.sv =====
// Top level: LFU cache with LRU tiebreak built as a chain of entry cells.
// Request channel (req): action get/put, key, write_value; valid/ready.
// Response channel (rsp): hit, read_value; exactly one transfer per request.
// Configuration: APB register 0 (byte 0) holds capacity_in_use, reset 16.
// Lookup: a request is looked up in the cycle after its transfer, with
// every cell comparing the key at once; a hit, a miss or an insert into a
// free entry has its response registered at the end of that lookup.
// A put that misses while the cache is at capacity runs the victim search
// down the cell chain in the sweep state, then installs into the victim in
// the evict state, where its response is registered.
// Flow: one request at a time; no new request is taken until the last one's
// response is registered. req.ready is high only while idle and the response
// register is empty or being emptied.
// Reset clears all valid marks, the fill count and the response valid flag.
// While a response is pending and rsp.ready is low, the response holds and no further request is taken.
module lfu_cache_lookup_update import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfu_req_if.sink     req,
  lfu_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "lfu_cache_lookup_update_macros.svh"

  localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned UW = $clog2(ENTRIES + 1);
  localparam int unsigned XW = (UW > CapW) ? UW : CapW;

  lfu_state_e state_q, state_d;
  logic [CapW-1:0] cap_q, cap_d;
  logic [UW-1:0]   used_q, used_d;
  logic [RW-1:0]   sweep_q, sweep_d;
  logic            act_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] wval_q;
  logic            rsp_valid_q, rsp_valid_d;
  logic            rsp_hit_q, rsp_hit_d;
  logic [ValW-1:0] rsp_val_q, rsp_val_d;

  lfu_ctl_t        ctl;
  logic [ENTRIES-1:0] sel, hit_vec, valid_vec, free_sel;
  logic [RW-1:0]   ref_rank;
  logic [ValW-1:0] cell_value [ENTRIES];
  logic [RW-1:0]   cell_rank [ENTRIES];
  lfu_cand_t       cand [ENTRIES+1];
  logic [RW-1:0]   cand_rank [ENTRIES+1];
  logic [RW-1:0]   cand_idx [ENTRIES+1];
  logic [ValW-1:0] hit_value;
  logic [RW-1:0]   hit_rank;
  logic            any_hit, cap_zero, full, accept, cfg_wr;
  logic [XW-1:0]   cap_eff;

  assign cand[0]      = '0;
  assign cand_rank[0] = '0;
  assign cand_idx[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(.RW(RW), .IDX(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .sel_i      (sel[g]),
      .ref_rank_i (ref_rank),
      .key_i      (key_q),
      .value_i    (wval_q),
      .cand_i     (cand[g]),
      .cand_rank_i(cand_rank[g]),
      .cand_idx_i (cand_idx[g]),
      .cand_o     (cand[g+1]),
      .cand_rank_o(cand_rank[g+1]),
      .cand_idx_o (cand_idx[g+1]),
      .valid_o    (valid_vec[g]),
      .match_o    (hit_vec[g]),
      .value_o    (cell_value[g]),
      .rank_o     (cell_rank[g])
    );
  end

  // keys are unique among valid cells, so the hit vector is one-hot or empty
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_value = hit_value | cell_value[i];
        hit_rank  = hit_rank | cell_rank[i];
      end
    end
  end

  always_comb begin
    free_sel = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_vec[i]) free_sel = ENTRIES'(1) << i;
    end
  end

  assign any_hit  = |hit_vec;
  assign cap_zero = (cap_q == '0);
  assign cap_eff  = (XW'(cap_q) > XW'(ENTRIES)) ? XW'(ENTRIES) : XW'(cap_q);
  assign full     = (XW'(used_q) >= cap_eff);
  assign accept   = req.valid && req.ready;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    sweep_d     = sweep_q;
    ctl         = '0;
    sel         = '0;
    ref_rank    = hit_rank;
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    rsp_hit_d   = rsp_hit_q;
    rsp_val_d   = rsp_val_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d     = S_IDLE;
        rsp_valid_d = 1'b1;
        rsp_hit_d   = 1'b0;
        rsp_val_d   = '0;
        if (act_q == ACT_GET) begin
          if (any_hit) begin
            rsp_hit_d    = 1'b1;
            rsp_val_d    = hit_value;
            ctl.apply    = 1'b1;
            sel          = hit_vec;
          end
        end else if (!cap_zero) begin
          if (any_hit) begin
            rsp_hit_d    = 1'b1;
            ctl.apply    = 1'b1;
            ctl.wr_value = 1'b1;
            sel          = hit_vec;
          end else if (!full) begin
            ctl.apply    = 1'b1;
            ctl.age_all  = 1'b1;
            ctl.install  = 1'b1;
            sel          = free_sel;
            used_d       = used_q + UW'(1);
          end else begin
            rsp_valid_d  = 1'b0;
            sweep_d      = '0;
            state_d      = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        sweep_d = sweep_q + RW'(1);
        if (sweep_q == RW'(ENTRIES - 1)) state_d = S_EVICT;
      end
      S_EVICT: begin
        // victim slot takes the new entry; newer entries age by one
        state_d     = S_IDLE;
        rsp_valid_d = 1'b1;
        rsp_hit_d   = 1'b0;
        rsp_val_d   = '0;
        ctl.apply   = 1'b1;
        ctl.install = 1'b1;
        ref_rank    = cand_rank[ENTRIES];
        for (int i = 0; i < ENTRIES; i++) begin
          sel[i] = (cand_idx[ENTRIES] == RW'(i));
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cap_d = cfg_wr ? pwdata[CapW-1:0] : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CapReset;
      used_q      <= '0;
      sweep_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      used_q      <= used_d;
      sweep_q     <= sweep_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= req.action;
      key_q  <= req.key;
      wval_q <= req.write_value;
    end
    rsp_hit_q <= rsp_hit_d;
    rsp_val_q <= rsp_val_d;
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.hit        = rsp_hit_q;
  assign rsp.read_value = rsp_val_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

  `LFU_ASSERT(a_hit_onehot, clk_i, rst_ni, $onehot0(hit_vec))
  `LFU_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= UW'(ENTRIES))
  `LFU_ASSERT_NEXT(a_accept_look, clk_i, rst_ni, accept, state_q == S_LOOK)
  `LFU_ASSERT_IMP(a_rsp_source, clk_i, rst_ni, $rose(rsp_valid_q),
                  $past(state_q == S_LOOK) || $past(state_q == S_EVICT))

endmodule

// ===== bench/tb.sv =====
// Testbench for lfu_cache_lookup_update: directed and random gets and puts, checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import lfu_pkg::*;

  localparam int Slots      = 16;
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_cache_lookup_update #(.ENTRIES(Slots)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req.sink),
    .rsp     (rsp.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  class lfu_scoreboard;
    typedef struct {
      logic        hit;
      logic [31:0] value;
    } answer_t;

    answer_t           awaited[$];
    bit                slot_valid[Slots];
    logic [31:0]       slot_key[Slots];
    logic [31:0]       slot_value[Slots];
    logic [CountW-1:0] slot_count[Slots];
    int unsigned       slot_rank[Slots];
    int unsigned       used;
    int unsigned       capacity;
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       hits;
    int unsigned       evictions;

    function new();
      capacity = 16;
      foreach (slot_valid[i]) slot_valid[i] = 0;
    endfunction

    task report(string what);
      $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    function void set_capacity(logic [CapW-1:0] v);
      capacity = v;
    endfunction

    function void promote(int s);
      for (int i = 0; i < Slots; i++)
        if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
      slot_rank[s] = 0;
      if (slot_count[s] != CountMax) slot_count[s]++;
    endfunction

    function void remove(int s);
      slot_valid[s] = 0;
      for (int i = 0; i < Slots; i++)
        if (slot_valid[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
      if (used > 0) used--;
    endfunction

    function void note_request(lfu_act_e act, logic [31:0] k, logic [31:0] w);
      answer_t     a;
      int          slot;
      int          victim;
      int unsigned lim;
      a.hit   = 0;
      a.value = '0;
      slot    = -1;
      victim  = -1;
      lim     = capacity > Slots ? Slots : capacity;
      requests++;
      for (int i = 0; i < Slots; i++)
        if (slot == -1 && slot_valid[i] && slot_key[i] == k) slot = i;
      if (act == ACT_GET) begin
        if (slot != -1) begin
          a.hit   = 1;
          a.value = slot_value[slot];
          promote(slot);
        end
      end else if (lim != 0) begin
        if (slot != -1) begin
          a.hit            = 1;
          slot_value[slot] = w;
          promote(slot);
        end else begin
          if (used >= lim) begin
            for (int i = 0; i < Slots; i++)
              if (slot_valid[i] && (victim == -1 || slot_count[i] < slot_count[victim] ||
                  (slot_count[i] == slot_count[victim] && slot_rank[i] > slot_rank[victim])))
                victim = i;
            if (victim != -1) begin
              remove(victim);
              evictions++;
            end
          end
          for (int i = 0; i < Slots; i++)
            if (slot == -1 && !slot_valid[i]) slot = i;
          if (slot != -1) begin
            for (int i = 0; i < Slots; i++)
              if (slot_valid[i]) slot_rank[i]++;
            slot_valid[slot] = 1;
            slot_key[slot]   = k;
            slot_value[slot] = w;
            slot_count[slot] = 1;
            slot_rank[slot]  = 0;
            used++;
          end
        end
      end
      if (a.hit) hits++;
      awaited.push_back(a);
    endfunction

    task check_response(logic h, logic [31:0] v);
      answer_t a;
      if (awaited.size() == 0) begin
        report("response transfer with nothing outstanding");
      end else begin
        a = awaited.pop_front();
        if (h !== a.hit) report($sformatf("hit %0b, predicted %0b", h, a.hit));
        if (v !== a.value) report($sformatf("read_value %h, predicted %h", v, a.value));
      end
    endtask
  endclass

  lfu_scoreboard sb;
  int unsigned   send_idle;
  int unsigned   recv_idle;
  bit            hold_rsp;
  int unsigned   quiet;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", QuietLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rsp.ready = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready) sb.check_response(rsp.hit, rsp.read_value);
      if (hold_rsp) begin
        rsp.ready <= 0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rsp = 0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(lfu_act_e act, logic [31:0] k, logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 0;
      @(posedge clk_i);
    end
    req.valid       <= 1;
    req.action      <= act;
    req.key         <= k;
    req.write_value <= w;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(act, k, w);
  endtask

  task automatic wait_idle();
    req.valid <= 0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (Slots + 8) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CapW-1:0] v);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= 3'(4 * REG_CAPACITY);
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.set_capacity(v);
    pwrite  <= 0;
    penable <= 0;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (prdata[CapW-1:0] !== v) sb.report($sformatf("capacity reads %h, wrote %h", prdata, v));
    psel    <= 0;
    penable <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(23);
    if ($urandom_range(9) >= 7) return $urandom;
    case (r)
      20:      return 32'h8000_0000;
      21:      return 32'h7fff_ffff;
      22:      return 32'hffff_ffff;
      default: return 32'(r);
    endcase
  endfunction

  localparam logic [31:0] KMin = 32'h8000_0000;
  localparam logic [31:0] KMax = 32'h7fff_ffff;

  initial begin
    int unsigned caps[12] = '{16, 4, 1, 31, 0, 7, 2, 16, 3, 5, 0, 12};
    sb              = new();
    send_idle       = 0;
    recv_idle       = 0;
    hold_rsp        = 0;
    quiet           = 0;
    rst_ni          = 0;
    req.valid       = 0;
    req.action      = ACT_GET;
    req.key         = '0;
    req.write_value = '0;
    psel            = 0;
    penable         = 0;
    pwrite          = 0;
    paddr           = '0;
    pwdata          = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, update, lowered capacity, zero and oversized capacity, single entry
    send_item(ACT_GET, 32'h0, 32'h0);
    send_item(ACT_PUT, KMin, KMax);
    send_item(ACT_PUT, KMax, KMin);
    send_item(ACT_PUT, 32'h0, 32'hffff_ffff);
    send_item(ACT_PUT, 32'hffff_ffff, 32'h0);
    send_item(ACT_GET, KMin, $urandom);
    send_item(ACT_GET, KMax, $urandom);
    send_item(ACT_PUT, KMax, 32'h1234_5678);
    send_item(ACT_GET, 32'hffff_ffff, 32'h0);
    wait_idle();
    set_capacity(3);
    send_item(ACT_PUT, 32'd5, 32'd55);
    send_item(ACT_PUT, 32'd6, 32'd66);
    send_item(ACT_GET, 32'h0, 32'h0);
    send_item(ACT_PUT, 32'd7, 32'd77);
    wait_idle();
    set_capacity(0);
    send_item(ACT_PUT, 32'd9, 32'd99);
    send_item(ACT_GET, 32'd5, 32'h0);
    send_item(ACT_GET, 32'd9, 32'h0);
    wait_idle();
    set_capacity(31);
    send_item(ACT_PUT, 32'd9, 32'd99);
    send_item(ACT_GET, 32'd9, 32'h0);
    wait_idle();
    set_capacity(1);
    send_item(ACT_PUT, 32'd1, 32'd11);
    send_item(ACT_PUT, 32'd2, 32'd22);
    send_item(ACT_GET, 32'd1, 32'h0);
    send_item(ACT_GET, 32'd2, 32'h0);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 20 : (p == 1) ? 75 : 0;
      recv_idle = (p == 0) ? 75 : (p == 1) ? 20 : 0;
      for (int c = 0; c < 4; c++) begin
        wait_idle();
        set_capacity(caps[p * 4 + c]);
        if (p == 0 && c == 1) hold_rsp = 1;
        repeat (52) send_item(lfu_act_e'($urandom_range(1)), pick_key(), $urandom);
      end
    end
    wait_idle();

    if (sb.awaited.size() != 0) sb.report("responses still outstanding at end");
    $display("covered %0d requests: %0d hits, %0d evictions, capacities 0 to 31",
             sb.requests, sb.hits, sb.evictions);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
